FILE: rtl/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, timing constants and the power-up pulse table for the
// character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // Timing constants (microseconds unless noted)
    localparam int SETTLE_US  = 40;
    localparam int STARTUP_MS = 100;

    localparam int BEFORE_MAX = 131071;
    localparam int AFTER_MAX  = 8191;

    localparam int STARTUP_RAW_US = STARTUP_MS * 1000;
    localparam int STARTUP_US     = (STARTUP_RAW_US > BEFORE_MAX) ? BEFORE_MAX
                                                                 : STARTUP_RAW_US;

    localparam int EXTRA_SHORT_US = 100;
    localparam int EXTRA_CLEAR_US = 2000;
    localparam int EXTRA_POWER_US = 5000;

    // Pulse counts
    localparam int INIT_PULSES = 12;
    localparam int PULSE_IDX_W = $clog2(INIT_PULSES);

    // LCD command bytes
    localparam logic [7:0] LCD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON     = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] LCD_CLR_DISPLAY = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
    localparam logic [3:0] LCD_WAKE_NIB    = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB    = 4'h2;

    // DDRAM row offsets
    localparam logic [7:0] ROW1_OFFSET = 8'h40;
    localparam logic [7:0] ROW2_OFFSET = 8'h10;
    localparam logic [7:0] ROW3_OFFSET = 8'h50;

    // Command codes on the input
    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_CHAR   = 3'd1,
        ACT_CURSOR = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_RAW    = 3'd4
    } action_t;

    // Extra delay added after enable falls
    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_SHORT,
        EXTRA_CLEAR,
        EXTRA_POWER
    } extra_t;

    // Queued command word between front and back
    typedef struct packed {
        logic       is_init;
        logic       is_clear;
        logic       sel;
        logic [7:0] cmd_byte;
        logic [1:0] cursor_mode;
    } cmd_desc_t;

    // One pulse as shown on the output
    typedef struct packed {
        logic [16:0] wait_before_us;
        logic        select_level;
        logic [3:0]  nibble;
        logic [12:0] wait_after_us;
        logic        last_pulse;
    } pulse_t;

    function automatic logic [12:0] sat_after(input int extra_us);
        int total;
        begin
            total = SETTLE_US + extra_us;
            sat_after = (total > AFTER_MAX) ? 13'(AFTER_MAX) : 13'(total);
        end
    endfunction

    function automatic logic [12:0] after_us(input extra_t extra);
        logic [12:0] res;
        begin
            case (extra)
                EXTRA_SHORT: res = sat_after(EXTRA_SHORT_US);
                EXTRA_CLEAR: res = sat_after(EXTRA_CLEAR_US);
                EXTRA_POWER: res = sat_after(EXTRA_POWER_US);
                default:     res = sat_after(0);
            endcase
            after_us = res;
        end
    endfunction

    // Power-up sequence nibble per pulse index
    function automatic logic [3:0] init_nibble(input logic [PULSE_IDX_W-1:0] idx,
                                               input logic [1:0] cursor_mode);
        logic [7:0] disp;
        logic [3:0] res;
        begin
            disp = LCD_DISP_ON | {6'd0, cursor_mode};
            unique case (idx)
                4'd0, 4'd1, 4'd2: res = LCD_WAKE_NIB;
                4'd3:             res = LCD_4BIT_NIB;
                4'd4:             res = LCD_FUNC_4BIT[7:4];
                4'd5:             res = LCD_FUNC_4BIT[3:0];
                4'd6:             res = disp[7:4];
                4'd7:             res = disp[3:0];
                4'd8:             res = LCD_CLR_DISPLAY[7:4];
                4'd9:             res = LCD_CLR_DISPLAY[3:0];
                4'd10:            res = LCD_ENTRY_MODE[7:4];
                4'd11:            res = LCD_ENTRY_MODE[3:0];
                default:          res = 4'd0;
            endcase
            init_nibble = res;
        end
    endfunction

    // Power-up sequence extra delay per pulse index
    function automatic extra_t init_extra(input logic [PULSE_IDX_W-1:0] idx);
        extra_t res;
        begin
            unique case (idx)
                4'd0, 4'd1: res = EXTRA_POWER;
                4'd2, 4'd3: res = EXTRA_SHORT;
                4'd9:       res = EXTRA_CLEAR;
                default:    res = EXTRA_NONE;
            endcase
            init_extra = res;
        end
    endfunction

endpackage

FILE: rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Output: a command's first pulse word is loaded into the output register
// while it heads the two-entry queue and the output is not stalled.
// Throughput: one pulse word per cycle while out_stall is low; init has 12
// pulses, every other command 2, set by the back sequencer's pulse counter.
// Reset: queue empty, no output, cursor_mode 3, register select command mode.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] wait_before_us,
    output logic        select_level,
    output logic [3:0]  nibble,
    output logic [12:0] wait_after_us,
    output logic        last_pulse
);

    logic      q_full;
    logic      push;
    cmd_desc_t push_desc;
    logic      pop;
    logic      head_valid;
    cmd_desc_t head_desc;
    pulse_t    out_pulse;
    logic      in_fire;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    // Decode stage
    lcdns_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_fire        (in_fire),
        .action         (action),
        .data_byte      (data_byte),
        .row            (row),
        .column         (column),
        .push           (push),
        .push_desc      (push_desc)
    );

    // Command queue
    lcdns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // Pulse sequencer
    lcdns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_pulse  (out_pulse)
    );

    assign wait_before_us = out_pulse.wait_before_us;
    assign select_level   = out_pulse.select_level;
    assign nibble         = out_pulse.nibble;
    assign wait_after_us  = out_pulse.wait_after_us;
    assign last_pulse     = out_pulse.last_pulse;

endmodule

FILE: rtl/lcdns_front.sv
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts command words, decodes them into a queued descriptor and keeps
// the cursor mode register and the remembered register select.
// ----------------------------------------------------------------------------
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic [1:0]      cfg_write_data,
    input  logic            in_fire,
    input  logic [2:0]      action,
    input  logic [7:0]      data_byte,
    input  logic [7:0]      row,
    input  logic [7:0]      column,
    output logic            push,
    output cmd_desc_t       push_desc
);

    logic [1:0] cursor_mode_reg;
    logic [1:0] cursor_mode_next;
    logic       select_reg;
    logic       select_next;
    logic [7:0] row_offset;
    logic       known;

    // Cursor mode register
    always_comb
    begin
        cursor_mode_next = cfg_write_en ? cfg_write_data : cursor_mode_reg;
    end

    // Row offset for set cursor
    always_comb
    begin
        case (row)
            8'd1:    row_offset = ROW1_OFFSET;
            8'd2:    row_offset = ROW2_OFFSET;
            8'd3:    row_offset = ROW3_OFFSET;
            default: row_offset = 8'd0;
        endcase
    end

    // Command decode
    always_comb
    begin
        known                 = 1'b1;
        select_next           = select_reg;
        push_desc.is_init     = 1'b0;
        push_desc.is_clear    = 1'b0;
        push_desc.sel         = 1'b0;
        push_desc.cmd_byte    = data_byte;
        push_desc.cursor_mode = cursor_mode_reg;
        unique case (action_t'(action))
            ACT_INIT:
            begin
                push_desc.is_init = 1'b1;
                select_next       = 1'b0;
            end
            ACT_CHAR:
            begin
                push_desc.sel = 1'b1;
                select_next   = 1'b1;
            end
            ACT_CURSOR:
            begin
                push_desc.cmd_byte = LCD_SET_DDRAM | row_offset | {4'd0, column[3:0]};
                select_next        = 1'b0;
            end
            ACT_CLEAR:
            begin
                push_desc.is_clear = 1'b1;
                push_desc.cmd_byte = LCD_CLR_DISPLAY;
                select_next        = 1'b0;
            end
            ACT_RAW:
            begin
                push_desc.sel = select_reg;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
        push = in_fire && known;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_mode_reg <= 2'd3;
            select_reg      <= 1'b0;
        end
        else
        begin
            cursor_mode_reg <= cursor_mode_next;
            if (in_fire)
            begin
                select_reg <= select_next;
            end
        end
    end

endmodule

FILE: rtl/lcdns_queue.sv
// ----------------------------------------------------------------------------
// lcdns_queue
// Two-entry queue of command descriptors between front and back.
// ----------------------------------------------------------------------------
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_desc_t push_desc,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output cmd_desc_t head_desc
);

    cmd_desc_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: rtl/lcdns_back.sv
// ----------------------------------------------------------------------------
// lcdns_back
// Steps through the pulses of the head command, one per cycle into the
// output register unless stalled, and pops the command with its last pulse.
// ----------------------------------------------------------------------------
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_desc_t head_desc,
    output logic      pop,
    input  logic      out_stall,
    output logic      out_valid,
    output pulse_t    out_pulse
);

    logic [PULSE_IDX_W-1:0] idx_reg;
    logic [PULSE_IDX_W-1:0] idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    pulse_t                 pulse_reg;
    pulse_t                 pulse_next;
    logic                   load;
    extra_t                 extra;

    assign out_valid = out_valid_reg;
    assign out_pulse = pulse_reg;

    // Pulse generation for the current index
    always_comb
    begin
        load = head_valid && (!out_valid_reg || !out_stall);

        pulse_next.select_level   = head_desc.sel;
        pulse_next.wait_before_us = 17'd0;
        extra                     = EXTRA_NONE;
        if (head_desc.is_init)
        begin
            pulse_next.select_level = 1'b0;
            pulse_next.nibble       = init_nibble(idx_reg, head_desc.cursor_mode);
            extra                   = init_extra(idx_reg);
            pulse_next.last_pulse   = (idx_reg == PULSE_IDX_W'(INIT_PULSES - 1));
            if (idx_reg == '0)
            begin
                pulse_next.wait_before_us = 17'(STARTUP_US);
            end
        end
        else
        begin
            pulse_next.last_pulse = idx_reg[0];
            pulse_next.nibble     = idx_reg[0] ? head_desc.cmd_byte[3:0]
                                               : head_desc.cmd_byte[7:4];
            if (idx_reg[0] && head_desc.is_clear)
            begin
                extra = EXTRA_CLEAR;
            end
        end
        pulse_next.wait_after_us = after_us(extra);

        pop      = load && pulse_next.last_pulse;
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = pulse_next.last_pulse ? '0 : idx_reg + PULSE_IDX_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pulse_reg <= pulse_next;
        end
    end

endmodule
